>>> sv/hpc_pkg.sv
// Shared types, constants and mod-26 helpers for the 2x2 Hill cipher block.
// No dependencies; imported by hpc_keygen and hill_pair_cipher_mod26_top.
`timescale 1ns / 1ps
`default_nettype none

package hpc_pkg;

    // Letter arithmetic
    localparam int          MODULUS    = 26;
    localparam logic [4:0]  PAD_LETTER = 5'd23;     // 'X'
    localparam logic [6:0]  UPPER_A    = 7'd65;     // 'A'
    localparam logic [7:0]  UPPER_A_B  = 8'd65;
    localparam logic [7:0]  UPPER_Z_B  = 8'd90;
    localparam logic [7:0]  LOWER_A_B  = 8'd97;
    localparam logic [7:0]  LOWER_Z_B  = 8'd122;

    // Reciprocal for x / 26 on values below 2048: floor(x * 2521 / 2^16)
    localparam int          RECIP26    = 2521;
    localparam int          RECIP_SH   = 16;

    // Configuration register indexes
    localparam int          CFG_IDX_W  = 3;
    localparam int          CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_KEY00   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY01   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY10   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY11   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT = 3'd4;

    // Cycles from a key write until the working matrix is settled
    localparam logic [2:0]  KEY_LAT    = 3'd4;

    // Working matrix: entry 0 top left, 1 top right, 2 bottom left, 3 bottom right
    typedef struct packed {
        logic [3:0][4:0] m;
        logic            ok;    // 0 when decrypting with a singular key
    } hpc_mat_t;

    // x mod 26 for x < 2048, by reciprocal multiply and one correction
    function automatic logic [4:0] mod26(input logic [10:0] x);
        logic [23:0] prod;
        logic [6:0]  q;
        logic [11:0] r;
        prod = 24'(x) * 24'(RECIP26);
        q    = prod[RECIP_SH+6:RECIP_SH];
        r    = 12'(x) - 12'(q) * 12'(MODULUS);
        if (r >= 12'(MODULUS))
            r = r - 12'(MODULUS);
        return r[4:0];
    endfunction

    // Reduce a 5-bit key entry into 0..25
    function automatic logic [4:0] fold26(input logic [4:0] k);
        return (k >= 5'(MODULUS)) ? k - 5'(MODULUS) : k;
    endfunction

    // Multiplicative inverse mod 26; 0 when none exists
    function automatic logic [4:0] inv26(input logic [4:0] d);
        logic [4:0] r;
        case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/hpc_keygen.sv
// Key registers and the pipelined derivation of the working matrix
// (key itself, or its inverse mod 26). Depends on hpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpc_keygen
    import hpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output hpc_mat_t              mat,
    output logic                  busy
);

    // Configuration registers
    logic [3:0][4:0] key_reg;
    logic            decrypt_reg;

    // Derivation pipeline
    logic [3:0][4:0] kr_a_reg, kr_b_reg, kr_c_reg;
    logic [9:0]      pad_reg, pbc_reg;
    logic            mode_a_reg, mode_b_reg, mode_c_reg;
    logic [4:0]      inv_reg;
    logic [3:0][9:0] prod_c_reg;
    logic            ok_c_reg;
    hpc_mat_t        mat_reg, mat_next;
    logic [2:0]      settle_reg;

    logic [3:0][4:0] kr_next;
    logic [10:0]     det_arg;
    logic [3:0][4:0] rem;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= {5'd1, 5'd0, 5'd0, 5'd1};
            decrypt_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_KEY00:   key_reg[0]  <= cfg_data;
                REG_KEY01:   key_reg[1]  <= cfg_data;
                REG_KEY10:   key_reg[2]  <= cfg_data;
                REG_KEY11:   key_reg[3]  <= cfg_data;
                REG_DECRYPT: decrypt_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Settle counter: starts full after reset and on every write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= KEY_LAT;
        else if (cfg_wr)
            settle_reg <= KEY_LAT;
        else if (settle_reg != 3'd0)
            settle_reg <= settle_reg - 3'd1;
    end

    assign busy = (settle_reg != 3'd0);

    // Stage A: fold keys, determinant products
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            kr_next[i] = fold26(key_reg[i]);
    end

    // Stage B: determinant mod 26, shifted positive by 25*26 before reducing
    assign det_arg = 11'(pad_reg) + 11'(MODULUS * 25) - 11'(pbc_reg);

    // Stage D: reduce adjugate products, select encrypt or decrypt matrix
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            rem[i] = mod26(11'(prod_c_reg[i]));
        if (!mode_c_reg)
        begin
            mat_next.m  = kr_c_reg;
            mat_next.ok = 1'b1;
        end
        else if (!ok_c_reg)
        begin
            mat_next.m  = '0;
            mat_next.ok = 1'b0;
        end
        else
        begin
            mat_next.m[0] = rem[0];
            mat_next.m[1] = (rem[1] == 5'd0) ? 5'd0 : 5'(MODULUS) - rem[1];
            mat_next.m[2] = (rem[2] == 5'd0) ? 5'd0 : 5'(MODULUS) - rem[2];
            mat_next.m[3] = rem[3];
            mat_next.ok   = 1'b1;
        end
    end

    // Pipeline registers; contents are covered by the settle counter
    always_ff @(posedge clk)
    begin
        kr_a_reg   <= kr_next;
        pad_reg    <= 10'(kr_next[0]) * 10'(kr_next[3]);
        pbc_reg    <= 10'(kr_next[1]) * 10'(kr_next[2]);
        mode_a_reg <= decrypt_reg;

        kr_b_reg   <= kr_a_reg;
        inv_reg    <= inv26(mod26(det_arg));
        mode_b_reg <= mode_a_reg;

        kr_c_reg      <= kr_b_reg;
        prod_c_reg[0] <= 10'(kr_b_reg[3]) * 10'(inv_reg);
        prod_c_reg[1] <= 10'(kr_b_reg[1]) * 10'(inv_reg);
        prod_c_reg[2] <= 10'(kr_b_reg[2]) * 10'(inv_reg);
        prod_c_reg[3] <= 10'(kr_b_reg[0]) * 10'(inv_reg);
        ok_c_reg      <= (inv_reg != 5'd0);
        mode_c_reg    <= mode_b_reg;

        mat_reg <= mat_next;
    end

    assign mat = mat_reg;

endmodule

`default_nettype wire

>>> sv/hill_pair_cipher_mod26_top.sv
// Top level of the 2x2 Hill cipher: letter pairing, matrix multiply mod 26,
// result queue and stream ports. Depends on hpc_pkg and hpc_keygen.
//
//  Port group   Dir  Beat contents
//  s_axis_*     in   tdata[7:0] message_byte, tlast end_of_message
//  m_axis_*     out  tdata[6:0] cipher_letter, tuser letter_valid/status, tlast last_result
//  cfg_*        in   cfg_index register index, cfg_data value (ready always high)
//
// One input byte per cycle while s_axis_tready is high. A pair of letters gives
// two output beats on consecutive cycles while m_axis_tready is high; a pair
// passes the pair and product registers on its way into the result queue.
// The result queue holds DEPTH items; s_axis_tready drops when items in flight
// would fill it, so output stalls back up into the input without loss.
// After reset and each configuration write the input stalls while keys settle.
`timescale 1ns / 1ps
`default_nettype none

module hill_pair_cipher_mod26_top
    import hpc_pkg::*;
#(
    parameter int DEPTH = 4     // result queue entries, 3 or more
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] message_byte
    input  logic                  s_axis_tlast,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [6:0] cipher_letter, [7] zero
    output logic [1:0]            m_axis_tuser,   // [0] letter_valid, [1] status
    output logic                  m_axis_tlast,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 3);

    typedef struct packed {
        logic [6:0] l0;
        logic [6:0] l1;
        logic       lv;
        logic       st;
        logic       last;
        logic       two;     // pair of beats, else a single end marker
    } entry_t;

    hpc_mat_t   mat;
    logic       key_busy;

    logic       in_fire, out_fire, pop;
    logic       is_upper, is_lower, is_letter;
    logic [4:0] v;

    logic       held_valid_reg;
    logic [4:0] held_letter_reg;

    logic       s1_v_reg, s1_two_reg, s1_last_reg;
    logic [4:0] s1_p0_reg, s1_p1_reg;
    logic       s1_v_next, s1_two_next, s1_last_next;
    logic [4:0] s1_p0_next, s1_p1_next;

    logic        s2_v_reg, s2_two_reg, s2_last_reg;
    logic [10:0] s2_sum0_reg, s2_sum1_reg;

    entry_t             fifo_mem_reg [DEPTH];
    entry_t             wr_entry, head;
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, inflight;
    logic               half_reg;

    // Key registers and working matrix
    hpc_keygen u_keygen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mat       (mat),
        .busy      (key_busy)
    );

    assign cfg_ready = 1'b1;

    // Credit check: queue plus pipeline must leave room for one more item
    assign inflight      = count_reg + CNT_W'(s1_v_reg) + CNT_W'(s2_v_reg);
    assign s_axis_tready = !key_busy && (inflight < CNT_W'(DEPTH));
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    // Letter decode
    assign is_upper  = (s_axis_tdata >= UPPER_A_B) && (s_axis_tdata <= UPPER_Z_B);
    assign is_lower  = (s_axis_tdata >= LOWER_A_B) && (s_axis_tdata <= LOWER_Z_B);
    assign is_letter = is_upper | is_lower;
    assign v         = is_lower ? 5'(s_axis_tdata - LOWER_A_B) : 5'(s_axis_tdata - UPPER_A_B);

    // Pair forming
    always_comb
    begin
        s1_v_next    = 1'b0;
        s1_two_next  = 1'b1;
        s1_last_next = s_axis_tlast;
        s1_p0_next   = held_letter_reg;
        s1_p1_next   = PAD_LETTER;
        if (in_fire)
        begin
            if (is_letter && held_valid_reg)
            begin
                s1_v_next  = 1'b1;
                s1_p1_next = v;
            end
            else if (is_letter && s_axis_tlast)
            begin
                s1_v_next  = 1'b1;
                s1_p0_next = v;
            end
            else if (!is_letter && s_axis_tlast)
            begin
                // held letter gets padded, otherwise a bare end marker
                s1_v_next   = 1'b1;
                s1_two_next = held_valid_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg  <= 1'b0;
            held_letter_reg <= 5'd0;
        end
        else if (in_fire)
        begin
            if (is_letter && !held_valid_reg && !s_axis_tlast)
            begin
                held_valid_reg  <= 1'b1;
                held_letter_reg <= v;
            end
            else if (s1_v_next)
            begin
                held_valid_reg  <= 1'b0;
                held_letter_reg <= 5'd0;
            end
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s1_v_reg;
        end
    end

    // Stage payloads: pair, then matrix products summed
    always_ff @(posedge clk)
    begin
        s1_two_reg  <= s1_two_next;
        s1_last_reg <= s1_last_next;
        s1_p0_reg   <= s1_p0_next;
        s1_p1_reg   <= s1_p1_next;

        s2_two_reg  <= s1_two_reg;
        s2_last_reg <= s1_last_reg;
        s2_sum0_reg <= 11'(mat.m[0]) * 11'(s1_p0_reg) + 11'(mat.m[1]) * 11'(s1_p1_reg);
        s2_sum1_reg <= 11'(mat.m[2]) * 11'(s1_p0_reg) + 11'(mat.m[3]) * 11'(s1_p1_reg);
    end

    // Reduce and format the queue entry
    always_comb
    begin
        wr_entry.two  = s2_two_reg;
        wr_entry.last = s2_last_reg;
        wr_entry.st   = !mat.ok;
        wr_entry.lv   = mat.ok && s2_two_reg;
        if (mat.ok && s2_two_reg)
        begin
            wr_entry.l0 = UPPER_A + 7'(mod26(s2_sum0_reg));
            wr_entry.l1 = UPPER_A + 7'(mod26(s2_sum1_reg));
        end
        else
        begin
            wr_entry.l0 = 7'd0;
            wr_entry.l1 = 7'd0;
        end
    end

    // Result queue
    assign head     = fifo_mem_reg[rd_ptr_reg];
    assign out_fire = m_axis_tvalid & m_axis_tready;
    assign pop      = out_fire && (half_reg || !head.two);

    always_ff @(posedge clk)
    begin
        if (s2_v_reg)
            fifo_mem_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            if (s2_v_reg)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (s2_v_reg && !pop)
                count_reg <= count_reg + 1'b1;
            else if (!s2_v_reg && pop)
                count_reg <= count_reg - 1'b1;
            if (pop)
                half_reg <= 1'b0;
            else if (out_fire)
                half_reg <= 1'b1;
        end
    end

    // Output beat from the head entry
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {1'b0, half_reg ? head.l1 : head.l0};
    assign m_axis_tuser  = {head.st, head.lv};
    assign m_axis_tlast  = head.last && (half_reg || !head.two);

endmodule

`default_nettype wire
